@@ hdl/mba_pkg.sv @@
// ----------------------------------------------------------------------------
// mba_pkg
// Shared constants for the masked background accumulator.
// ----------------------------------------------------------------------------
package mba_pkg;

	localparam int SMP_W       = 8;
	localparam int WGT_W       = 8;
	localparam int NUM_W       = 16;   // bg*w + s
	localparam int DIV_W       = 9;    // w + 1
	localparam int RECIP_SHIFT = 17;
	localparam int RECIP_W     = 18;
	localparam int REM_W       = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam logic [WGT_W-1:0] WGT_MAX = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTEND_MARGIN = 2'd3;

	localparam logic CMD_FRAME_START = 1'b0;
	localparam logic CMD_PIXEL       = 1'b1;

	localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [9:0]  FRAME_HEIGHT_RST = 10'd480;
	localparam logic [7:0]  MARGIN_RST       = 8'd40;

	// per-item control that travels down the pipeline
	typedef struct packed {
		logic pixel;
		logic in_range;
		logic in_box;
		logic last;
		logic unseen;
	} mba_ctl_t;

endpackage

@@ hdl/mba_blend.sv @@
// ----------------------------------------------------------------------------
// mba_blend
// Running-average blend (bg*w + s)/(w+1), round half to even, three stages.
// ----------------------------------------------------------------------------
module mba_blend (
	input  logic                       clk,
	input  logic                       en,
	input  logic [mba_pkg::SMP_W-1:0]  bg,
	input  logic [mba_pkg::WGT_W-1:0]  w,
	input  logic [mba_pkg::SMP_W-1:0]  smp,
	output logic [mba_pkg::SMP_W-1:0]  result
);

	localparam int NW = mba_pkg::NUM_W;
	localparam int DW = mba_pkg::DIV_W;
	localparam int RW = mba_pkg::RECIP_W;
	localparam int PW = NW + RW;
	localparam int SH = mba_pkg::RECIP_SHIFT;
	localparam int EW = mba_pkg::REM_W;

	// floor(2^SH / (w+1)), indexed by w
	logic [RW-1:0] recip_tab [256];
	for (genvar i = 0; i < 256; i++) begin : g_tab
		localparam logic [RW-1:0] R = RW'((1 << SH) / (i + 1));
		assign recip_tab[i] = R;
	end

	logic [NW-1:0] n_s3, n_s4, n_s5;
	logic [DW-1:0] d_s3, d_s4, d_s5;
	logic [RW-1:0] recip_s3;
	logic [PW-1:0] p_s4;
	logic [7:0]    q0_s5;
	logic [NW-1:0] qd_s5;

	logic [NW-1:0] n_c;
	logic [7:0]    q0_c;
	logic [EW-1:0] r0, r1, r2x;
	logic [8:0]    q1, q2;

	assign n_c  = NW'(bg) * NW'(w) + NW'(smp);
	assign q0_c = p_s4[SH+7:SH];

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3     <= n_c;
			d_s3     <= DW'(w) + DW'(1);
			recip_s3 <= recip_tab[w];
			n_s4     <= n_s3;
			d_s4     <= d_s3;
			p_s4     <= PW'(n_s3) * PW'(recip_s3);
			n_s5     <= n_s4;
			d_s5     <= d_s4;
			q0_s5    <= q0_c;
			qd_s5    <= NW'(q0_c) * NW'(d_s4);
		end
	end

	// estimate is exact or one low
	always_comb begin
		r0 = EW'(n_s5 - qd_s5);
		if (r0 >= EW'(d_s5)) begin
			q1 = {1'b0, q0_s5} + 9'd1;
			r1 = r0 - EW'(d_s5);
		end else begin
			q1 = {1'b0, q0_s5};
			r1 = r0;
		end
		r2x = {r1[EW-2:0], 1'b0};
		if (r2x > EW'(d_s5) || (r2x == EW'(d_s5) && q1[0]))
			q2 = q1 + 9'd1;
		else
			q2 = q1;
		result = q2[8] ? 8'd255 : q2[7:0];
	end

endmodule

@@ hdl/masked_background_accumulator.sv @@
// ----------------------------------------------------------------------------
// masked_background_accumulator
// Per-pixel running-average background model masked by a widened object box.
// ----------------------------------------------------------------------------
// One item per clock unless the output stalls or a store hazard holds; five
// stages from input to result register: box test and store read, operand
// build, reciprocal multiply, remainder check, then round, write-back and
// result. A pixel whose entry is still being updated further down holds at
// the first stage until the write lands. After reset a clearing pass writes
// every store entry (524288 by default), one per cycle, with input not ready.
module masked_background_accumulator #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [mba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// box_left, box_top, box_right, box_bottom, column, row, sample_a,
	// sample_b, sample_c, zero pad
	input  logic [87:0] s_axis_tdata,
	input  logic        s_axis_tlast,   // frame_end
	input  logic        s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// background_a, background_b, background_c, weight
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,   // last_of_frame
	output logic        m_axis_tuser    // background_ready
);

	localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW     = ($clog2(MAX_COLUMNS + 1) > 11) ? $clog2(MAX_COLUMNS + 1) : 11;
	localparam int RW     = ($clog2(MAX_ROWS + 1) > 10) ? $clog2(MAX_ROWS + 1) : 10;
	localparam int ENT_W  = 33;

	// configuration
	logic        mode_q;
	logic [10:0] fwidth_q;
	logic [9:0]  fheight_q;
	logic [7:0]  margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			fwidth_q  <= mba_pkg::FRAME_WIDTH_RST;
			fheight_q <= mba_pkg::FRAME_HEIGHT_RST;
			margin_q  <= mba_pkg::MARGIN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mba_pkg::REG_CHANNEL_MODE:  mode_q    <= cfg_wdata[0];
				mba_pkg::REG_FRAME_WIDTH:   fwidth_q  <= cfg_wdata;
				mba_pkg::REG_FRAME_HEIGHT:  fheight_q <= cfg_wdata[9:0];
				mba_pkg::REG_EXTEND_MARGIN: margin_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] fw_eff;
	logic [RW-1:0] fh_eff;
	always_comb begin
		if (fwidth_q == '0)
			fw_eff = CW'(1);
		else if (CW'(fwidth_q) > CW'(MAX_COLUMNS))
			fw_eff = CW'(MAX_COLUMNS);
		else
			fw_eff = CW'(fwidth_q);
		if (fheight_q == '0)
			fh_eff = RW'(1);
		else if (RW'(fheight_q) > RW'(MAX_ROWS))
			fh_eff = RW'(MAX_ROWS);
		else
			fh_eff = RW'(fheight_q);
	end

	// clearing pass
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	// pipeline control
	logic adv, go_s1, hazard, in_acc;
	logic out_valid_q;
	logic valid_s1;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !clearing_q && (!valid_s1 || go_s1);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// stage 1: input register
	logic        cmd_s1, last_s1;
	logic [9:0]  bl_s1, br_s1, col_s1;
	logic [8:0]  bt_s1, bb_s1, row_s1;
	logic [7:0]  sa_s1, sb_s1, sc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (go_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bl_s1   <= s_axis_tdata[9:0];
			bt_s1   <= s_axis_tdata[18:10];
			br_s1   <= s_axis_tdata[28:19];
			bb_s1   <= s_axis_tdata[37:29];
			col_s1  <= s_axis_tdata[47:38];
			row_s1  <= s_axis_tdata[56:48];
			sa_s1   <= s_axis_tdata[64:57];
			sb_s1   <= s_axis_tdata[72:65];
			sc_s1   <= s_axis_tdata[80:73];
			cmd_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	// widened box
	logic [9:0]    wl_q;
	logic [8:0]    wt_q;
	logic [CW-1:0] wr_q;
	logic [RW-1:0] wb_q;
	logic [9:0]    nl;
	logic [8:0]    nt;
	logic [CW-1:0] nr_raw, nr;
	logic [RW-1:0] nb_raw, nb;

	always_comb begin
		nl     = (bl_s1 >= 10'(margin_q)) ? bl_s1 - 10'(margin_q) : '0;
		nt     = (bt_s1 >= 9'(margin_q)) ? bt_s1 - 9'(margin_q) : '0;
		nr_raw = CW'(br_s1) + CW'(margin_q);
		nb_raw = RW'(bb_s1) + RW'(margin_q);
		nr     = (nr_raw > fw_eff - CW'(1)) ? fw_eff - CW'(1) : nr_raw;
		nb     = (nb_raw > fh_eff - RW'(1)) ? fh_eff - RW'(1) : nb_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0;
			wt_q <= '0;
			wr_q <= '0;
			wb_q <= '0;
		end else if (valid_s1 && go_s1 && cmd_s1 == mba_pkg::CMD_FRAME_START) begin
			wl_q <= nl;
			wt_q <= nt;
			wr_q <= nr;
			wb_q <= nb;
		end
	end

	logic              in_range_s1, in_box_s1, wr_s1;
	logic [ADDR_W-1:0] addr_s1;

	assign in_range_s1 = (CW'(col_s1) < fw_eff) && (RW'(row_s1) < fh_eff);
	assign in_box_s1   = col_s1 >= wl_q && CW'(col_s1) <= wr_q &&
	                     row_s1 >= wt_q && RW'(row_s1) <= wb_q;
	assign addr_s1     = ADDR_W'(ADDR_W'(row_s1) * ADDR_W'(MAX_COLUMNS)) + ADDR_W'(col_s1);
	assign wr_s1       = valid_s1 && cmd_s1 == mba_pkg::CMD_PIXEL && in_range_s1;

	// stages 2..5 carry control, address and old entry
	logic              valid_s2, valid_s3, valid_s4, valid_s5;
	mba_pkg::mba_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [ADDR_W-1:0] addr_s2, addr_s3, addr_s4, addr_s5;
	logic [23:0]       bg_s3, bg_s4, bg_s5;
	logic [7:0]        w_s3, w_s4, w_s5;
	logic [7:0]        sa_s2, sb_s2, sc_s2;
	logic [ENT_W-1:0]  mem_q;

	function automatic logic wr_of(input logic v, input mba_pkg::mba_ctl_t c);
		return v && c.pixel && c.in_range;
	endfunction

	assign hazard = wr_s1 && (
		(wr_of(valid_s2, ctl_s2) && addr_s2 == addr_s1) ||
		(wr_of(valid_s3, ctl_s3) && addr_s3 == addr_s1) ||
		(wr_of(valid_s4, ctl_s4) && addr_s4 == addr_s1) ||
		(wr_of(valid_s5, ctl_s5) && addr_s5 == addr_s1));
	assign go_s1 = adv && !hazard;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && !hazard;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	mba_pkg::mba_ctl_t ctl_c_s2;
	always_comb begin
		ctl_c_s2        = ctl_s2;
		ctl_c_s2.unseen = mem_q[32];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2.pixel    <= cmd_s1 == mba_pkg::CMD_PIXEL;
			ctl_s2.in_range <= in_range_s1;
			ctl_s2.in_box   <= in_box_s1;
			ctl_s2.last     <= last_s1;
			ctl_s2.unseen   <= 1'b0;
			addr_s2         <= addr_s1;
			sa_s2           <= sa_s1;
			sb_s2           <= sb_s1;
			sc_s2           <= sc_s1;
			ctl_s3  <= ctl_c_s2;
			addr_s3 <= addr_s2;
			bg_s3   <= mem_q[23:0];
			w_s3    <= mem_q[31:24];
			ctl_s4  <= ctl_s3;
			addr_s4 <= addr_s3;
			bg_s4   <= bg_s3;
			w_s4    <= w_s3;
			ctl_s5  <= ctl_s4;
			addr_s5 <= addr_s4;
			bg_s5   <= bg_s4;
			w_s5    <= w_s4;
		end
	end

	// blend units, operands from stage 2, results at stage 5
	logic [7:0] bl_a, bl_b, bl_c;

	mba_blend u_blend_a (.clk(clk), .en(adv), .bg(mem_q[7:0]),   .w(mem_q[31:24]),
		.smp(sa_s2), .result(bl_a));
	mba_blend u_blend_b (.clk(clk), .en(adv), .bg(mem_q[15:8]),  .w(mem_q[31:24]),
		.smp(sb_s2), .result(bl_b));
	mba_blend u_blend_c (.clk(clk), .en(adv), .bg(mem_q[23:16]), .w(mem_q[31:24]),
		.smp(sc_s2), .result(bl_c));

	// stage 5: final values
	logic [7:0] fa, fb, fc, fwgt;
	logic       f_unseen, wr_s5;

	always_comb begin
		if (ctl_s5.in_box) begin
			fa       = bg_s5[7:0];
			fb       = bg_s5[15:8];
			fc       = bg_s5[23:16];
			fwgt     = w_s5;
			f_unseen = ctl_s5.unseen;
		end else begin
			fa       = bl_a;
			fb       = bl_b;
			fc       = bl_c;
			fwgt     = (w_s5 == mba_pkg::WGT_MAX) ? w_s5 : w_s5 + 8'd1;
			f_unseen = 1'b0;
		end
		if (!mode_q) begin
			fb = '0;
			fc = '0;
		end
		if (!ctl_s5.in_range) begin
			fa   = '0;
			fb   = '0;
			fc   = '0;
			fwgt = '0;
		end
	end

	assign wr_s5 = adv && wr_of(valid_s5, ctl_s5);

	// entry: unseen, weight, background c/b/a
	logic [ENT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_cnt_q] <= {1'b1, 32'd0};
		else if (wr_s5)
			mem[addr_s5] <= {f_unseen, fwgt, fc, fb, fa};
	end

	always_ff @(posedge clk) begin
		if (adv)
			mem_q <= mem[addr_s1];
	end

	// frame status and result register
	logic any_unseen_q, any_next;
	assign any_next = any_unseen_q || (ctl_s5.in_range && f_unseen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_unseen_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s5 && ctl_s5.pixel;
			if (valid_s5) begin
				if (!ctl_s5.pixel || ctl_s5.last)
					any_unseen_q <= 1'b0;
				else
					any_unseen_q <= any_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {fwgt, fc, fb, fa};
			m_axis_tlast <= ctl_s5.last;
			m_axis_tuser <= ctl_s5.last && !any_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule
